### hdl/mdre_pkg.sv
package mdre_pkg;

  // Widths of the configuration write channel.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_UMC_HARDWARE_ID = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_UMC_BANK_TYPE   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_DRAM_ECC   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CODE_ECS_ROW    = 8'd3;

  // Error cause codes carried in payload word four.
  localparam logic [2:0] CAUSE_CORRECTED = 3'd1;
  localparam logic [2:0] CAUSE_DEFERRED  = 3'd3;

  // Device field reported for a corrected error.
  localparam logic [4:0] DEVICE_CORRECTED = 5'h1F;

  // One machine-check record as taken in.
  typedef struct packed {
    logic [63:0] mca_status;
    logic [63:0] mca_address;
    logic [63:0] mca_ipid;
    logic [4:0]  syndrome_low;
    logic [63:0] translated_address;
  } mca_record_t;

  // Configuration register set.
  typedef struct packed {
    logic [11:0] umc_hardware_id;
    logic [15:0] umc_bank_type;
    logic [5:0]  code_dram_ecc;
    logic [5:0]  code_ecs_row;
  } mdre_cfg_t;

  // One repair entry as delivered.
  typedef struct packed {
    logic [63:0] repair_words_low;
    logic [15:0] repair_word_four;
    logic [31:0] phys_address_low;
    logic [7:0]  phys_address_high;
    logic        runtime_repair_wanted;
  } repair_entry_t;

endpackage

### hdl/mdre_cfg_regs.sv
module mdre_cfg_regs
  import mdre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output mdre_cfg_t              cfg
);

  // Register file: a write to an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_UMC_HARDWARE_ID: cfg.umc_hardware_id <= wr_data[11:0];
        REG_UMC_BANK_TYPE:   cfg.umc_bank_type   <= wr_data[15:0];
        REG_CODE_DRAM_ECC:   cfg.code_dram_ecc   <= wr_data[5:0];
        REG_CODE_ECS_ROW:    cfg.code_ecs_row    <= wr_data[5:0];
        default: begin
        end
      endcase
    end
  end

endmodule

### hdl/mdre_decode.sv
module mdre_decode
  import mdre_pkg::*;
(
  input  mca_record_t   rec,
  input  mdre_cfg_t     cfg,
  output logic          hit,
  output repair_entry_t entry
);

  logic        tvalid;
  logic        uc;
  logic        corrected;
  logic [5:0]  ece;
  logic        is_ecc;
  logic        bank_match;
  logic [3:0]  chan_full;
  logic [4:0]  device;
  logic [2:0]  cause;
  logic [1:0]  cs;
  logic        sub;
  logic [4:0]  bank;
  logic [10:0] col;
  logic [17:0] row;
  logic [2:0]  rank;
  logic [3:0]  chan;
  logic [2:0]  sock;
  logic [31:0] alo;
  logic [7:0]  ahi;
  logic [15:0] w0;
  logic [15:0] w1;
  logic [15:0] w2;
  logic [15:0] w3;

  // Record filter: memory-controller bank, not uncorrected, known error code.
  always_comb begin
    tvalid     = rec.translated_address[62];
    uc         = rec.mca_status[61];
    corrected  = !rec.mca_status[44];
    ece        = rec.mca_status[21:16];
    is_ecc     = (ece == cfg.code_dram_ecc);
    bank_match = (rec.mca_ipid[43:32] == cfg.umc_hardware_id) &&
                 (rec.mca_ipid[63:48] == cfg.umc_bank_type);
    hit        = bank_match && !uc && (is_ecc || (ece == cfg.code_ecs_row));
  end

  // Channel is controller number halved plus die index times eight, four bits kept.
  assign chan_full = {rec.mca_ipid[44], rec.mca_ipid[23:21]};
  assign cause     = corrected ? CAUSE_CORRECTED : CAUSE_DEFERRED;
  assign device    = corrected ? DEVICE_CORRECTED : rec.translated_address[46:42];

  // Field decode along the ECC path or the scrub row path.
  always_comb begin
    cs   = '0;
    sub  = 1'b0;
    bank = '0;
    col  = '0;
    row  = '0;
    rank = '0;
    chan = '0;
    sock = '0;
    alo  = '0;
    ahi  = '0;
    if (is_ecc) begin
      cs  = rec.syndrome_low[1:0];
      sub = rec.syndrome_low[4];
      if (tvalid) begin
        bank = rec.translated_address[6:2];
        col  = rec.translated_address[35:25];
        row  = rec.translated_address[24:7];
        rank = rec.translated_address[38:36];
        chan = chan_full;
        sock = rec.translated_address[60:58];
      end
      alo = rec.mca_address[35:4];
      ahi = {4'h0, rec.mca_address[39:36]};
    end else begin
      bank = rec.mca_address[22:18];
      chan = chan_full;
      sock = rec.translated_address[60:58];
      if (tvalid) begin
        rank = rec.translated_address[38:36];
        alo  = rec.translated_address[31:0];
        ahi  = rec.translated_address[39:32];
      end
    end
  end

  // Pack the repair payload words.
  assign w0 = {col[0], cs, device, bank, 3'b000};
  assign w1 = {1'b1, 5'b00000, col[10:1]};
  assign w2 = row[15:0];
  assign w3 = {sock, 3'b000, sub, chan, rank, row[17:16]};

  always_comb begin
    entry.repair_words_low      = {w3, w2, w1, w0};
    entry.repair_word_four      = {10'h000, cause, 3'b000};
    entry.phys_address_low      = alo;
    entry.phys_address_high     = ahi;
    entry.runtime_repair_wanted = corrected;
  end

endmodule

### hdl/mca_error_to_dram_repair_entry.sv
// A record taken into the input register gives its repair entry, if any,
// on the strobe from the result register that follows it.
// Throughput: one record every cycle; busy is never raised.
// The receiver cannot stall, so each entry is shown for exactly one cycle.
// Reset clears the configuration registers to zero and drops records in flight.
module mca_error_to_dram_repair_entry
  import mdre_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [63:0]            mca_status,
  input  logic [63:0]            mca_address,
  input  logic [63:0]            mca_ipid,
  input  logic [4:0]             syndrome_low,
  input  logic [63:0]            translated_address,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [63:0]            repair_words_low,
  output logic [15:0]            repair_word_four,
  output logic [31:0]            phys_address_low,
  output logic [7:0]             phys_address_high,
  output logic                   runtime_repair_wanted
);

  mdre_cfg_t     cfg;
  mca_record_t   rec;
  logic          rec_valid;
  logic          hit;
  repair_entry_t entry;
  repair_entry_t result;

  // The pipeline never holds off a new transaction.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  mdre_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else begin
      rec_valid <= start && !busy;
    end
    if (start && !busy) begin
      rec.mca_status         <= mca_status;
      rec.mca_address        <= mca_address;
      rec.mca_ipid           <= mca_ipid;
      rec.syndrome_low       <= syndrome_low;
      rec.translated_address <= translated_address;
    end
  end

  mdre_decode u_decode (
    .rec   (rec),
    .cfg   (cfg),
    .hit   (hit),
    .entry (entry)
  );

  // Result register; the strobe marks an accepted record.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rec_valid && hit;
    end
    if (rec_valid && hit) begin
      result <= entry;
    end
  end

  assign repair_words_low      = result.repair_words_low;
  assign repair_word_four      = result.repair_word_four;
  assign phys_address_low      = result.phys_address_low;
  assign phys_address_high     = result.phys_address_high;
  assign runtime_repair_wanted = result.runtime_repair_wanted;

`ifndef SYNTHESIS
  // An entry only follows a record taken in through the input and result registers.
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("repair entry without a record taken two cycles before");

  // The cause follows the corrected flag.
  a_cause_matches: assert property (@(posedge clk) disable iff (rst)
    done |-> (repair_word_four ==
              (runtime_repair_wanted ? 16'h0008 : 16'h0018)))
    else $error("cause does not match the corrected flag");

  // A corrected error always reports the fixed device value.
  a_device_corrected: assert property (@(posedge clk) disable iff (rst)
    (done && runtime_repair_wanted) |-> (repair_words_low[12:8] == DEVICE_CORRECTED))
    else $error("corrected error with a decoded device");

  // The fixed marker bit of payload word one is always set and the low bits of word zero are clear.
  a_word_one_marker: assert property (@(posedge clk) disable iff (rst)
    done |-> (repair_words_low[31] && (repair_words_low[2:0] == 3'b000)))
    else $error("fixed payload bits are wrong");
`endif

endmodule

### tb/sv/tb_mca_error_to_dram_repair_entry.sv
module tb_mca_error_to_dram_repair_entry;
  import mdre_pkg::*;

  // How the bulk of a generated record is filled before its key fields are forced.
  typedef enum {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_kind_t;

  // Ways in which a record is spoilt so that the block must drop it.
  typedef enum {
    SPOIL_RANDOM, SPOIL_UNCORRECTED, SPOIL_HW_ID, SPOIL_BANK_TYPE, SPOIL_CODE
  } spoil_kind_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   done;
  logic [63:0]            repair_words_low;
  logic [15:0]            repair_word_four;
  logic [31:0]            phys_address_low;
  logic [7:0]             phys_address_high;
  logic                   runtime_repair_wanted;

  mca_record_t   drive_rec = '0;
  mca_record_t   record_queue[$];
  repair_entry_t awaited_entries[$];
  repair_entry_t predicted_entry;
  repair_entry_t observed_entry;
  mdre_cfg_t     active_cfg = '0;
  logic          record_taken = 1'b0;
  int            idle_pct = 0;
  int            records_taken = 0;
  int            entries_checked = 0;
  int            settings_used = 1;
  int            error_count = 0;

  mca_error_to_dram_repair_entry DUT (
    .clk                   (clk),
    .rst                   (rst),
    .start                 (start),
    .busy                  (busy),
    .mca_status            (drive_rec.mca_status),
    .mca_address           (drive_rec.mca_address),
    .mca_ipid              (drive_rec.mca_ipid),
    .syndrome_low          (drive_rec.syndrome_low),
    .translated_address    (drive_rec.translated_address),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .done                  (done),
    .repair_words_low      (repair_words_low),
    .repair_word_four      (repair_word_four),
    .phys_address_low      (phys_address_low),
    .phys_address_high     (phys_address_high),
    .runtime_repair_wanted (runtime_repair_wanted)
  );

  always #2 clk = ~clk;

  // Works out the repair entry for one record, or returns 0 when the record is dropped.
  function automatic bit predict_repair_entry(input mca_record_t rec, input mdre_cfg_t cfg,
                                              output repair_entry_t entry);
    logic [5:0]  ext_code;
    logic        corrected;
    logic        taddr_ok;
    logic [4:0]  device;
    logic [4:0]  bank;
    logic [2:0]  chip_sel;
    logic        sub_chan;
    logic [10:0] col;
    logic [17:0] row;
    logic [2:0]  rank;
    logic [2:0]  sock;
    logic [3:0]  chan;
    logic [3:0]  chan_full;
    logic [31:0] addr_lo;
    logic [7:0]  addr_hi;
    logic [2:0]  cause;
    logic [15:0] w0, w1, w2, w3;
    entry = '0;
    ext_code = rec.mca_status[21:16];
    if (rec.mca_ipid[43:32] != cfg.umc_hardware_id ||
        rec.mca_ipid[63:48] != cfg.umc_bank_type || rec.mca_status[61] ||
        (ext_code != cfg.code_dram_ecc && ext_code != cfg.code_ecs_row))
      return 1'b0;

    corrected = !rec.mca_status[44];
    taddr_ok  = rec.translated_address[62];
    cause     = corrected ? CAUSE_CORRECTED : CAUSE_DEFERRED;
    device    = corrected ? DEVICE_CORRECTED : rec.translated_address[46:42];
    // Controller number halved plus die index times eight, kept to four bits:
    // only the lowest die bit survives.
    chan_full = {1'b0, rec.mca_ipid[23:21]} + {rec.mca_ipid[44], 3'b000};
    chip_sel = '0; sub_chan = 1'b0; bank = '0; col = '0; row = '0; rank = '0;
    chan = '0; sock = '0; addr_lo = '0; addr_hi = '0;

    // The ECC path wins when both codes are the same.
    if (ext_code == cfg.code_dram_ecc) begin
      chip_sel = rec.syndrome_low[2:0];
      sub_chan = rec.syndrome_low[4];
      if (taddr_ok) begin
        bank = rec.translated_address[6:2];
        col  = rec.translated_address[35:25];
        row  = rec.translated_address[24:7];
        rank = rec.translated_address[38:36];
        chan = chan_full;
        sock = rec.translated_address[60:58];
      end
      addr_lo = rec.mca_address[35:4];
      addr_hi = {4'b0000, rec.mca_address[39:36]};
    end else begin
      bank = rec.mca_address[22:18];
      chan = chan_full;
      sock = rec.translated_address[60:58];
      if (taddr_ok) begin
        rank    = rec.translated_address[38:36];
        addr_lo = rec.translated_address[31:0];
        addr_hi = rec.translated_address[39:32];
      end
    end

    // Chip select bit 2 has no place in the entry.
    w0 = {col[0], chip_sel[1:0], device, bank, 3'b000};
    w1 = {1'b1, 5'b00000, col[10:1]};
    w2 = row[15:0];
    w3 = {sock, 3'b000, sub_chan, chan, rank, row[17:16]};
    entry.repair_words_low      = {w3, w2, w1, w0};
    entry.repair_word_four      = {10'b0, cause, 3'b000};
    entry.phys_address_low      = addr_lo;
    entry.phys_address_high     = addr_hi;
    entry.runtime_repair_wanted = corrected;
    return 1'b1;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Builds a record that passes every acceptance test under the current settings.
  function automatic mca_record_t make_record(input bit want_ecs, input bit deferred,
                                              input bit taddr_ok, input fill_kind_t fill);
    mca_record_t rec;
    case (fill)
      FILL_ONES:  rec = '1;
      FILL_ZEROS: rec = '0;
      default: begin
        rec.mca_status         = rand64();
        rec.mca_address        = rand64();
        rec.mca_ipid           = rand64();
        rec.syndrome_low       = 5'($urandom);
        rec.translated_address = rand64();
      end
    endcase
    rec.mca_status[61]        = 1'b0;
    rec.mca_status[44]        = deferred;
    rec.mca_status[21:16]     = want_ecs ? active_cfg.code_ecs_row : active_cfg.code_dram_ecc;
    rec.mca_ipid[43:32]       = active_cfg.umc_hardware_id;
    rec.mca_ipid[63:48]       = active_cfg.umc_bank_type;
    rec.translated_address[62] = taddr_ok;
    return rec;
  endfunction

  // Takes a well-formed record and breaks one acceptance condition, or refills it at random.
  function automatic mca_record_t spoil_record(input mca_record_t rec, input spoil_kind_t kind);
    logic [5:0] code;
    case (kind)
      SPOIL_UNCORRECTED: rec.mca_status[61] = 1'b1;
      SPOIL_HW_ID:       rec.mca_ipid[43:32] ^= 12'($urandom_range(1, 4095));
      SPOIL_BANK_TYPE:   rec.mca_ipid[63:48] ^= 16'($urandom_range(1, 65535));
      SPOIL_CODE: begin
        do code = 6'($urandom);
        while (code == active_cfg.code_dram_ecc || code == active_cfg.code_ecs_row);
        rec.mca_status[21:16] = code;
      end
      default: begin
        rec.mca_status         = rand64();
        rec.mca_address        = rand64();
        rec.mca_ipid           = rand64();
        rec.syndrome_low       = 5'($urandom);
        rec.translated_address = rand64();
      end
    endcase
    return rec;
  endfunction

  task automatic report_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Appends one record to the tail of the sender's queue.
  task automatic queue_record(input mca_record_t rec);
    record_queue.insert(record_queue.size(), rec);
  endtask

  // Sender: hands out one queued record per transaction, idling at random.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || record_taken) begin
      if (record_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drive_rec <= record_queue.pop_front();
        start     <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Register writes, record transactions and repair entries as seen at the clock edge.
  always @(posedge clk) begin
    if (rst) begin
      record_taken <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_UMC_HARDWARE_ID: active_cfg.umc_hardware_id = cfg_data[11:0];
          REG_UMC_BANK_TYPE:   active_cfg.umc_bank_type   = cfg_data[15:0];
          REG_CODE_DRAM_ECC:   active_cfg.code_dram_ecc   = cfg_data[5:0];
          REG_CODE_ECS_ROW:    active_cfg.code_ecs_row    = cfg_data[5:0];
          default: ;
        endcase
      end

      // Entries are checked before this edge's record is predicted.
      if (done) begin
        observed_entry = '{repair_words_low, repair_word_four, phys_address_low,
                           phys_address_high, runtime_repair_wanted};
        if (awaited_entries.size() == 0) begin
          $display("%0t: unexpected repair entry: expected none, actual %h",
                   $time, observed_entry);
          error_count++;
        end else begin
          predicted_entry = awaited_entries.pop_front();
          report_field("repair_words_low", predicted_entry.repair_words_low,
                       observed_entry.repair_words_low);
          report_field("repair_word_four", 64'(predicted_entry.repair_word_four),
                       64'(observed_entry.repair_word_four));
          report_field("phys_address_low", 64'(predicted_entry.phys_address_low),
                       64'(observed_entry.phys_address_low));
          report_field("phys_address_high", 64'(predicted_entry.phys_address_high),
                       64'(observed_entry.phys_address_high));
          report_field("runtime_repair_wanted", 64'(predicted_entry.runtime_repair_wanted),
                       64'(observed_entry.runtime_repair_wanted));
          entries_checked++;
        end
      end

      record_taken <= start && !busy;
      if (start && !busy) begin
        records_taken++;
        if (predict_repair_entry(drive_rec, active_cfg, predicted_entry))
          awaited_entries.insert(awaited_entries.size(), predicted_entry);
      end
    end
  end

  // One register write; the caller lowers valid after the last of a sequence.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Writes all four registers with noise in the unused upper data bits, optionally also an unused index.
  task automatic apply_settings(input logic [11:0] hw_id, input logic [15:0] bank_type,
                                input logic [5:0] ecc_code, input logic [5:0] ecs_code,
                                input bit poke_unused);
    logic [CFG_DATA_W-1:0] value;
    value = 16'($urandom); value[11:0] = hw_id;
    write_register(REG_UMC_HARDWARE_ID, value);
    write_register(REG_UMC_BANK_TYPE, bank_type);
    value = 16'($urandom); value[5:0] = ecc_code;
    write_register(REG_CODE_DRAM_ECC, value);
    value = 16'($urandom); value[5:0] = ecs_code;
    write_register(REG_CODE_ECS_ROW, value);
    if (poke_unused)
      write_register(CFG_INDEX_W'($urandom_range(REG_CODE_ECS_ROW + 1, {CFG_INDEX_W{1'b1}})),
                     16'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Waits for the sender to run dry and every entry to arrive, then lets the pipeline empty.
  task automatic drain_block();
    int waited;
    while (record_queue.size() != 0 || start) @(posedge clk);
    waited = 0;
    while (awaited_entries.size() != 0 && waited < 100) begin
      @(negedge clk);
      waited++;
    end
    if (awaited_entries.size() != 0) begin
      $display("%0t: %0d repair entries never arrived: expected %h, actual none",
               $time, awaited_entries.size(), awaited_entries[0]);
      error_count += awaited_entries.size();
      awaited_entries.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  // Mostly well-formed records with random content, the rest spoilt.
  task automatic run_phase(input int idle, input int count);
    mca_record_t rec;
    @(posedge clk);
    idle_pct = idle;
    repeat (count) begin
      rec = make_record(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), FILL_RANDOM);
      if ($urandom_range(0, 99) < 80)
        queue_record(rec);
      else
        queue_record(spoil_record(rec,
          spoil_kind_t'($urandom_range(SPOIL_RANDOM, SPOIL_CODE))));
    end
    drain_block();
  endtask

  initial begin
    mca_record_t rec;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Settings left at reset: both codes are zero, so the ECC path is taken.
    @(posedge clk);
    queue_record(make_record(0, 0, 1, FILL_ZEROS));
    queue_record(make_record(1, 1, 1, FILL_ONES));
    queue_record(make_record(1, 0, 0, FILL_RANDOM));
    run_phase(0, 200);

    // Extreme ids with the ECC code at its top and the scrub code at zero.
    apply_settings(12'hFFF, 16'hFFFF, 6'd63, 6'd0, 1'b1);
    @(posedge clk);
    queue_record(make_record(0, 0, 1, FILL_ONES));
    queue_record(make_record(0, 1, 1, FILL_ONES));
    queue_record(make_record(0, 0, 0, FILL_ONES));
    queue_record(make_record(0, 1, 1, FILL_ZEROS));
    queue_record(make_record(0, 1, 0, FILL_ZEROS));
    queue_record(make_record(1, 0, 1, FILL_ONES));
    queue_record(make_record(1, 1, 0, FILL_ONES));
    queue_record(make_record(1, 0, 1, FILL_ZEROS));
    queue_record(make_record(1, 1, 0, FILL_ZEROS));
    queue_record(spoil_record(make_record(0, 0, 1, FILL_RANDOM), SPOIL_UNCORRECTED));
    queue_record(spoil_record(make_record(1, 1, 1, FILL_ONES), SPOIL_UNCORRECTED));
    queue_record(spoil_record(make_record(0, 0, 1, FILL_RANDOM), SPOIL_HW_ID));
    queue_record(spoil_record(make_record(1, 0, 1, FILL_RANDOM), SPOIL_BANK_TYPE));
    queue_record(spoil_record(make_record(0, 1, 1, FILL_RANDOM), SPOIL_CODE));
    // Channel overflow: largest controller number and die index.
    rec = make_record(1, 0, 1, FILL_RANDOM);
    rec.mca_ipid[23:20] = 4'hF;
    rec.mca_ipid[47:44] = 4'hF;
    queue_record(rec);
    // Lone syndrome bit 3, which is ignored, and lone chip select bit 2, which is dropped.
    rec = make_record(0, 0, 1, FILL_RANDOM);
    rec.syndrome_low = 5'b01000;
    queue_record(rec);
    rec.syndrome_low = 5'b00100;
    queue_record(rec);
    run_phase(0, 300);

    // Random settings under a mostly idle sender.
    apply_settings(12'($urandom), 16'($urandom), 6'($urandom), 6'($urandom), 1'b0);
    run_phase(88, 300);

    // Both codes the same.
    rec.mca_status[21:16] = 6'($urandom);
    apply_settings(12'($urandom), 16'($urandom), rec.mca_status[21:16],
                   rec.mca_status[21:16], 1'b0);
    run_phase(8, 300);

    // Ids at zero, scrub code at its top.
    apply_settings(12'h000, 16'h0000, 6'd0, 6'd63, 1'b0);
    run_phase(0, 300);

    apply_settings(12'($urandom), 16'($urandom), 6'($urandom), 6'($urandom), 1'b1);
    run_phase(88, 400);

    $display("Took %0d machine-check records under %0d register settings,",
             records_taken, settings_used);
    $display("checked %0d repair entries, %0d mismatches.", entries_checked, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
